// File: rtl/core/plic_pkg.sv
package plic_pkg;

    localparam int NumSourcesDef   = 31;
    localparam int PriorityBitsDef = 3;
    localparam int PrioDepth       = 32;
    localparam int IdBits          = 5;

    // register byte offsets, bits 1:0 ignored
    localparam logic [21:0] OFS_PENDING   = 22'h001000;
    localparam logic [21:0] OFS_ENABLE    = 22'h002000;
    localparam logic [21:0] OFS_THRESHOLD = 22'h200000;
    localparam logic [21:0] OFS_CLAIM     = 22'h200004;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_SCAN_END,
        ST_CLAIM,
        ST_OUT
    } t_state;

    // control from the sequencer to the shared compare unit
    typedef struct packed {
        logic              start;
        logic              cmp_vld;
        logic [IdBits-1:0] cmp_id;
    } t_arb_ctl;

endpackage

// File: rtl/core/plic_ram.sv
module plic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/plic_arb.sv
module plic_arb
    import plic_pkg::*;
#(
    parameter int PRIORITY_BITS = PriorityBitsDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_arb_ctl                 i_ctl,
    input  logic [31:0]              i_cand,
    input  logic [PRIORITY_BITS-1:0] i_threshold,
    input  logic [PRIORITY_BITS-1:0] i_prio,
    output logic [IdBits-1:0]        o_best_id
);

    logic [PRIORITY_BITS-1:0] r_best_prio;
    logic [IdBits-1:0]        r_best_id;

    // strict greater keeps the lowest id on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_id   <= '0;
            r_best_prio <= '0;
        end else if (i_ctl.start) begin
            r_best_id   <= '0;
            r_best_prio <= i_threshold;
        end else if (i_ctl.cmp_vld && i_cand[i_ctl.cmp_id] && (i_prio > r_best_prio)) begin
            r_best_id   <= i_ctl.cmp_id;
            r_best_prio <= i_prio;
        end
    end

    assign o_best_id = r_best_id;

endmodule

// File: rtl/core/platform_interrupt_controller.sv
// the result word follows a priority scan that reads one source a cycle from the priority ram;
// a claim read runs the scan again after the claim
// the input side is ready only while the sequencer is idle
// a finished result waits in the output register while the next word is accepted
// reset: synchronous, active low; priorities, enable, threshold, pending and in service read 0
module platform_interrupt_controller
    import plic_pkg::*;
#(
    parameter int NUM_SOURCES   = NumSourcesDef,
    parameter int PRIORITY_BITS = PriorityBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // byte_offset[21:0], write_data[53:22], source_lines[85:54]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_data[31:0], external_irq[32]
);

    localparam int          PB      = PRIORITY_BITS;
    localparam logic [31:0] SrcMask = (32'hFFFF_FFFF >> (31 - NUM_SOURCES)) & ~32'd1;
    localparam logic [IdBits-1:0] LastId = IdBits'(NUM_SOURCES);

    // sequencer and item registers
    t_state       r_state, n_state;
    t_opcode      r_op;
    logic [21:0]  r_ofs;
    logic [31:0]  r_data;
    logic [31:0]  r_lines;
    logic         r_claim_done;

    // architectural state
    logic [31:0]  r_pending;
    logic [31:0]  r_enable;
    logic [31:0]  r_in_service;
    logic [PB-1:0] r_threshold;
    logic [PrioDepth-1:0] r_prio_vld;   // entry written since reset

    // scan pipeline
    logic [IdBits-1:0] r_idx;
    logic              r_cmp_vld;
    logic [IdBits-1:0] r_cmp_id;
    logic              r_rvld;

    logic [31:0]  r_rd;
    logic [39:0]  r_out_data;
    logic         r_out_vld;

    // ram and arbiter hookup
    logic              w_we;
    logic [IdBits-1:0] w_raddr;
    logic [PB-1:0]     w_rdata;
    logic [PB-1:0]     w_prio;
    logic [IdBits-1:0] w_best;
    t_arb_ctl          w_ctl;

    // address decode
    logic [21:0]  w_ofs;
    logic [9:0]   w_word_id;
    logic [IdBits-1:0] w_pid;
    logic         w_is_prio, w_is_pend, w_is_en, w_is_thr, w_is_claim;
    logic [IdBits-1:0] w_cid;
    logic         w_complete_ok;
    logic         w_is_claim_read;
    logic [31:0]  w_reg_rd;

    assign w_ofs      = {r_ofs[21:2], 2'b00};
    assign w_word_id  = w_ofs[11:2];
    assign w_pid      = w_word_id[IdBits-1:0];
    assign w_is_prio  = (w_ofs < OFS_PENDING) && (w_word_id != 10'd0)
                        && (w_word_id <= 10'(NUM_SOURCES));
    assign w_is_pend  = (w_ofs == OFS_PENDING);
    assign w_is_en    = (w_ofs == OFS_ENABLE);
    assign w_is_thr   = (w_ofs == OFS_THRESHOLD);
    assign w_is_claim = (w_ofs == OFS_CLAIM);
    assign w_is_claim_read = (r_op == OP_READ) && w_is_claim;

    // plain register reads answered in apply
    assign w_reg_rd = w_is_pend ? r_pending :
                      w_is_en   ? r_enable  :
                      w_is_thr  ? {{(32-PB){1'b0}}, r_threshold} : '0;

    // complete only for a valid, enabled id
    assign w_cid         = r_data[IdBits-1:0];
    assign w_complete_ok = (r_data[31:IdBits] == '0) && (w_cid != '0)
                           && (w_cid <= LastId) && r_enable[w_cid];

    // an entry never written reads as priority zero
    assign w_prio = r_rvld ? w_rdata : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_APPLY;
            end
            ST_APPLY: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_idx == LastId) n_state = ST_SCAN_END;
            end
            ST_SCAN_END: begin
                if (w_is_claim_read && !r_claim_done) n_state = ST_CLAIM;
                else                                  n_state = ST_OUT;
            end
            ST_CLAIM: n_state = ST_SCAN;
            ST_OUT: begin
                if (!r_out_vld || m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_we          = 1'b0;
        w_raddr       = r_idx;
        w_ctl.start   = 1'b0;
        w_ctl.cmp_vld = r_cmp_vld;
        w_ctl.cmp_id  = r_cmp_id;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_APPLY: begin
                w_we        = (r_op == OP_WRITE) && w_is_prio;
                w_raddr     = w_pid;
            end
            // threshold settles in apply, so the arbiter is seeded on the first scan cycle
            ST_SCAN:  w_ctl.start = !r_cmp_vld;
            ST_CLAIM: w_ctl.start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pending    <= '0;
            r_enable     <= '0;
            r_in_service <= '0;
            r_threshold  <= '0;
            r_prio_vld   <= '0;
            r_cmp_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
            r_claim_done <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state <= n_state;
            r_rvld  <= r_prio_vld[w_raddr];
            if (r_state == ST_OUT && (!r_out_vld || m_axis_tready)) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op         <= t_opcode'(s_axis_tuser);
                        r_ofs        <= s_axis_tdata[21:0];
                        r_data       <= s_axis_tdata[53:22];
                        r_lines      <= s_axis_tdata[85:54];
                        r_claim_done <= 1'b0;
                    end
                end
                ST_APPLY: begin
                    r_idx     <= IdBits'(1);
                    r_cmp_vld <= 1'b0;
                    r_rd      <= (r_op == OP_READ) ? w_reg_rd : '0;
                    case (r_op)
                        OP_SAMPLE: r_pending <= r_pending | (r_lines & SrcMask & ~r_in_service);
                        OP_WRITE: begin
                            if (w_is_prio) r_prio_vld[w_pid] <= 1'b1;
                            if (w_is_en)   r_enable <= r_data & SrcMask;
                            if (w_is_thr)  r_threshold <= r_data[PB-1:0];
                            if (w_is_claim && w_complete_ok) r_in_service[w_cid] <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                ST_SCAN: begin
                    // first scan cycle sees the priority fetched in apply
                    if (!r_cmp_vld && (r_op == OP_READ) && w_is_prio && !r_claim_done) begin
                        r_rd <= {{(32-PB){1'b0}}, w_prio};
                    end
                    r_cmp_vld <= 1'b1;
                    r_cmp_id  <= r_idx;
                    r_idx     <= r_idx + IdBits'(1);
                end
                ST_SCAN_END: r_cmp_vld <= 1'b0;
                ST_CLAIM: begin
                    r_rd         <= {{(32-IdBits){1'b0}}, w_best};
                    r_claim_done <= 1'b1;
                    r_idx        <= IdBits'(1);
                    if (w_best != '0) begin
                        r_pending[w_best]    <= 1'b0;
                        r_in_service[w_best] <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_out_data <= {7'd0, (w_best != '0), r_rd};
                    end
                end
                default: ;
            endcase
        end
    end

    plic_ram #(
        .WIDTH (PB),
        .DEPTH (PrioDepth)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_pid),
        .i_wdata (r_data[PB-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    plic_arb #(
        .PRIORITY_BITS (PB)
    ) u_arb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_cand      (r_pending & r_enable),
        .i_threshold (r_threshold),
        .i_prio      (w_prio),
        .o_best_id   (w_best)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // a source is never pending and in service at once
    a_pend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending & r_in_service) == '0)
        else $error("pending and in service overlap");

    // no state bit outside sources 1..NUM_SOURCES
    a_src_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pending | r_enable | r_in_service) & ~SrcMask) == '0)
        else $error("state bit outside source range");

    // the reported winner is enabled and pending
    a_best_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_best != '0) |-> (r_enable[w_best] && r_pending[w_best]))
        else $error("winner not enabled and pending");

    // a result appears only from the output step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_OUT))
        else $error("result loaded outside output step");

endmodule

// File: dv/platform_interrupt_controller_tb.sv
module platform_interrupt_controller_tb;
    import plic_pkg::*;

    localparam int RandomWords = 1200;
    localparam int TailWords   = 150;     // last words go out with no idling on either side
    localparam int DrainCycles = 80;
    localparam int CycleLimit  = 600000;
    localparam int LongHold    = 500;

    localparam logic [31:0] SrcMask  = (32'hFFFF_FFFF >> (31 - NumSourcesDef)) & ~32'd1;
    localparam logic [31:0] PrioMask = (32'd1 << PriorityBitsDef) - 32'd1;

    typedef struct {
        t_opcode     op;
        logic [21:0] offset;
        logic [31:0] wdata;
        logic [31:0] lines;
    } t_plic_word;

    typedef struct {
        logic [31:0] read_data;
        logic        irq;
    } t_plic_result;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata  = '0;    // byte_offset[21:0], write_data[53:22], source_lines[85:54]
    logic [1:0]  s_axis_tuser  = '0;    // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // read_data[31:0], external_irq[32]

    platform_interrupt_controller u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // shadow copy of the controller state
    logic [PriorityBitsDef-1:0] prio_q [PrioDepth];
    logic [31:0]                enable_q;
    logic [31:0]                threshold_q;
    logic [31:0]                pending_q;
    logic [31:0]                in_service_q;

    t_plic_word   word_q [$];
    t_plic_result result_q [$];
    t_plic_word   next_word;
    t_plic_result want;
    int           src_gap        = 0;
    int           sink_hold      = 0;
    bit           long_hold_done = 1'b0;
    int           words_checked  = 0;
    int           mismatches     = 0;
    int           cycle_cnt      = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [21:0] prio_offset(input int id);
        return 22'(id) << 2;
    endfunction

    // highest enabled pending priority above threshold, lowest id wins a tie
    function automatic int winning_source();
        logic [31:0] cand;
        logic [31:0] best_prio;
        int          best;
        cand      = pending_q & enable_q & SrcMask;
        best_prio = threshold_q;
        best      = 0;
        for (int id = 1; id <= NumSourcesDef; id++) begin
            if (cand[id] && 32'(prio_q[id]) > best_prio) begin
                best      = id;
                best_prio = 32'(prio_q[id]);
            end
        end
        return best;
    endfunction

    task automatic predict_word(input logic [1:0] op, input logic [87:0] data);
        logic [21:0]  ofs;
        logic [31:0]  wdata;
        logic [31:0]  lines;
        t_plic_result res;
        int           id;
        ofs           = data[21:0] & ~22'd3;
        wdata         = data[53:22];
        lines         = data[85:54];
        res.read_data = '0;
        case (op)
            OP_SAMPLE: begin
                // in-service sources ignore their line until completed
                pending_q = pending_q | (lines & SrcMask & ~in_service_q);
            end
            OP_READ: begin
                if (ofs < OFS_PENDING) begin
                    id = int'(ofs >> 2);
                    if (id >= 1 && id <= NumSourcesDef) res.read_data = 32'(prio_q[id]);
                end else if (ofs == OFS_PENDING) begin
                    res.read_data = pending_q;
                end else if (ofs == OFS_ENABLE) begin
                    res.read_data = enable_q;
                end else if (ofs == OFS_THRESHOLD) begin
                    res.read_data = threshold_q;
                end else if (ofs == OFS_CLAIM) begin
                    id = winning_source();
                    if (id != 0) begin
                        pending_q[id]    = 1'b0;
                        in_service_q[id] = 1'b1;
                    end
                    res.read_data = 32'(id);
                end
            end
            OP_WRITE: begin
                if (ofs < OFS_PENDING) begin
                    id = int'(ofs >> 2);
                    if (id >= 1 && id <= NumSourcesDef) prio_q[id] = wdata[PriorityBitsDef-1:0];
                end else if (ofs == OFS_ENABLE) begin
                    enable_q = wdata & SrcMask;
                end else if (ofs == OFS_THRESHOLD) begin
                    threshold_q = wdata & PrioMask;
                end else if (ofs == OFS_CLAIM) begin
                    // complete only for a valid, enabled id
                    if (wdata >= 1 && wdata <= NumSourcesDef && enable_q[wdata[4:0]])
                        in_service_q[wdata[4:0]] = 1'b0;
                end
            end
            default: ;
        endcase
        res.irq = (winning_source() != 0);
        result_q.push_back(res);
    endtask

    task automatic push_word(input t_opcode op, input logic [21:0] ofs,
                             input logic [31:0] wdata, input logic [31:0] lines);
        t_plic_word w;
        w.op     = op;
        w.offset = ofs;
        w.wdata  = wdata;
        w.lines  = lines;
        word_q.push_back(w);
    endtask

    // mostly register traffic that drives sources through pending, claim and complete
    function automatic t_plic_word random_word();
        t_plic_word w;
        int         pick;
        w.op     = OP_READ;
        w.offset = 22'($urandom);
        w.wdata  = $urandom;
        w.lines  = $urandom;
        pick     = $urandom_range(0, 99);
        if (pick < 20) begin
            w.op = OP_SAMPLE;
            if (pick < 8) w.lines = $urandom & $urandom & $urandom;
        end else if (pick < 35) begin
            w.offset = OFS_CLAIM;
        end else if (pick < 47) begin
            w.op     = OP_WRITE;
            w.offset = OFS_CLAIM;
            if (pick != 46) w.wdata = $urandom_range(1, NumSourcesDef);
        end else if (pick < 57) begin
            w.op     = OP_WRITE;
            w.offset = prio_offset($urandom_range(1, NumSourcesDef));
        end else if (pick < 62) begin
            w.op     = OP_WRITE;
            w.offset = OFS_ENABLE;
            w.wdata  = $urandom | $urandom;
        end else if (pick < 66) begin
            w.op     = OP_WRITE;
            w.offset = OFS_THRESHOLD;
            if (pick < 65) w.wdata = $urandom_range(0, 3);
        end else if (pick < 80) begin
            case (pick % 4)
                0:       w.offset = prio_offset($urandom_range(0, 40));
                1:       w.offset = OFS_PENDING;
                2:       w.offset = OFS_ENABLE;
                default: w.offset = OFS_THRESHOLD;
            endcase
        end else if (pick < 90) begin
            w.op = t_opcode'($urandom_range(0, 3));
        end else if (pick < 95) begin
            // mapped register with stray low offset bits
            w.op     = t_opcode'($urandom_range(1, 2));
            w.offset = ((pick % 2) ? OFS_CLAIM : OFS_ENABLE) | 22'($urandom_range(1, 3));
        end else begin
            w.op = OP_NONE;
        end
        return w;
    endfunction

    // sender: one word in flight, random gaps between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_word(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    next_word      = word_q.pop_front();
                    s_axis_tuser  <= next_word.op;
                    s_axis_tdata  <= {2'b00, next_word.lines, next_word.wdata, next_word.offset};
                    s_axis_tvalid <= 1'b1;
                    if (word_q.size() >= TailWords && $urandom_range(0, 4) == 0)
                        src_gap <= $urandom_range(1, 16);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result word, stalls in bursts and once for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_hold     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                words_checked++;
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", m_axis_tdata);
                end else begin
                    want = result_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.read_data || m_axis_tdata[32] !== want.irq) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: read_data exp %h got %h, irq exp %b got %b",
                                     words_checked, want.read_data, m_axis_tdata[31:0],
                                     want.irq, m_axis_tdata[32]);
                    end
                end
            end
            if (!long_hold_done && words_checked >= 300) begin
                long_hold_done <= 1'b1;
                sink_hold      <= LongHold;
                m_axis_tready  <= 1'b0;
            end else if (sink_hold != 0) begin
                sink_hold     <= sink_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (word_q.size() >= TailWords && $urandom_range(0, 9) == 0) begin
                sink_hold     <= $urandom_range(1, 16);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < PrioDepth; i++) prio_q[i] = '0;
        enable_q     = '0;
        threshold_q  = '0;
        pending_q    = '0;
        in_service_q = '0;

        // reset values
        push_word(OP_READ,  OFS_ENABLE,      32'h0, 32'h0);
        push_word(OP_READ,  OFS_THRESHOLD,   32'h0, 32'h0);
        push_word(OP_READ,  OFS_PENDING,     32'h0, 32'h0);
        // priority extremes, wide data, source zero and ids past the last source
        push_word(OP_WRITE, prio_offset(1),  32'h0000_0007, 32'h0);
        push_word(OP_WRITE, prio_offset(NumSourcesDef), 32'hFFFF_FFFE, 32'h0);
        push_word(OP_WRITE, prio_offset(0),  32'h0000_0005, 32'h0);
        push_word(OP_READ,  prio_offset(0),  32'h0, 32'h0);
        push_word(OP_WRITE, prio_offset(40), 32'h0000_0003, 32'h0);
        push_word(OP_READ,  prio_offset(32), 32'h0, 32'h0);
        // enable bit 0 never sticks, threshold keeps its low bits
        push_word(OP_WRITE, OFS_ENABLE,      32'hFFFF_FFFF, 32'h0);
        push_word(OP_READ,  OFS_ENABLE,      32'h0, 32'h0);
        push_word(OP_WRITE, OFS_THRESHOLD,   32'hFFFF_FFF9, 32'h0);
        push_word(OP_READ,  OFS_THRESHOLD,   32'h0, 32'h0);
        // all lines high, pending is read-only
        push_word(OP_SAMPLE, 22'h3F_FFFF,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(OP_WRITE, OFS_PENDING,     32'h0, 32'h0);
        push_word(OP_READ,  OFS_PENDING,     32'h0, 32'h0);
        // two claims win, zero-priority sources never qualify
        push_word(OP_READ,  OFS_CLAIM,       32'h0, 32'h0);
        push_word(OP_READ,  OFS_CLAIM,       32'h0, 32'h0);
        push_word(OP_READ,  OFS_CLAIM,       32'h0, 32'h0);
        push_word(OP_SAMPLE, 22'h0,          32'h0, 32'hFFFF_FFFF);
        // completes with a bad id, a disabled id and an id not in service
        push_word(OP_WRITE, OFS_CLAIM,       32'd0, 32'h0);
        push_word(OP_WRITE, OFS_CLAIM,       32'd32, 32'h0);
        push_word(OP_WRITE, OFS_ENABLE,      32'h7FFF_FFFC, 32'h0);
        push_word(OP_WRITE, OFS_CLAIM,       32'd1, 32'h0);
        push_word(OP_WRITE, OFS_CLAIM | 22'd3, 32'd5, 32'h0);
        push_word(OP_WRITE, OFS_CLAIM | 22'd3, 32'd31, 32'h0);
        // idle opcode and unmapped offsets
        push_word(OP_NONE,  OFS_CLAIM,       32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(OP_READ,  22'h00_3000,     32'h0, 32'h0);
        push_word(OP_WRITE, 22'h00_3000,     32'hFFFF_FFFF, 32'h0);
        push_word(OP_SAMPLE, 22'h0,          32'h0, 32'hFFFF_FFFF);
        push_word(OP_READ,  OFS_PENDING,     32'h0, 32'h0);

        for (int i = 0; i < RandomWords; i++) word_q.push_back(random_word());

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/plic_pkg.sv
rtl/core/plic_ram.sv
rtl/core/plic_arb.sv
rtl/core/platform_interrupt_controller.sv
dv/platform_interrupt_controller_tb.sv
